FILE: hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared codes, types and defaults of the priority task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int MAX_TASKS_DEF  = 8;
  localparam int TICK_WIDTH_DEF = 32;

  localparam logic [2:0] OP_CREATE   = 3'd0;
  localparam logic [2:0] OP_DELAY    = 3'd1;
  localparam logic [2:0] OP_SUSPEND  = 3'd2;
  localparam logic [2:0] OP_ACTIVATE = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  typedef logic [1:0] tstat_t;

  localparam tstat_t ST_READY     = 2'd0;
  localparam tstat_t ST_RUNNING   = 2'd1;
  localparam tstat_t ST_WAITING   = 2'd2;
  localparam tstat_t ST_SUSPENDED = 2'd3;

  // per-field write enables of the task table
  typedef struct packed {
    logic prio;
    logic stat;
    logic cnt;
  } pts_we_t;

endpackage

`default_nettype wire

FILE: hw/rtl/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Task table and dispatcher of a small preemptive kernel: applies one
// operation per item, then scans the table to pick the running task.
//
//   channel  ports                                         handshake
//   input    operation prio auto_start delay_ticks         start, busy
//            target_task
//   result   running_task switch_flag new_handle status    done strobe
//            clock_value
//
// busy is high from accept through the operation state, the scan, which reads
// each created task through the single read port and waits out the registered
// read latency before it closes, and the status write states S_FIX and S_SET.
// done is registered in S_SET and rises as busy falls; the result is taken
// with it.
// Reset clears the task count, the clock and selects the idle task.
// done lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_scheduler import pts_pkg::*; #(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  prio,
  input  wire logic        auto_start,
  input  wire logic [31:0] delay_ticks,
  input  wire logic [2:0]  target_task,
  output logic             done,
  output logic [3:0]       running_task,
  output logic             switch_flag,
  output logic [2:0]       new_handle,
  output logic             status,
  output logic [31:0]      clock_value
);

  localparam int ADDR_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int IDX_W  = $clog2(MAX_TASKS + 1);
  localparam int TGT_W  = (IDX_W > 3) ? IDX_W : 3;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_SET  = 3'd4;

  logic [2:0]            state;
  logic [IDX_W-1:0]      count;
  logic [IDX_W-1:0]      cur;
  logic [TICK_WIDTH-1:0] gclock;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rv;
  logic [IDX_W-1:0]      rv_idx;
  tstat_t                cur_stat;
  logic [IDX_W-1:0]      handle;
  logic                  refused;

  logic [2:0]            op_q;
  logic [7:0]            prio_q;
  logic                  auto_q;
  logic [31:0]           ticks_q;
  logic [2:0]            target_q;

  pts_we_t               we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [7:0]            wr_prio;
  tstat_t                wr_stat;
  logic [TICK_WIDTH-1:0] wr_wait;
  logic [7:0]            rd_prio;
  tstat_t                rd_stat;
  logic [TICK_WIDTH-1:0] rd_wait;

  logic                  issue;
  logic                  cur_task;
  logic                  upd_we;
  tstat_t                upd_stat;
  logic [TICK_WIDTH-1:0] upd_wait;
  logic [TICK_WIDTH-1:0] dly;
  logic [IDX_W-1:0]      next_sel;
  logic                  fix_cond;

  assign busy     = (state != S_IDLE);
  assign issue    = (rd_idx < count);
  assign cur_task = (cur < count);
  assign dly      = TICK_WIDTH'(ticks_q);
  assign fix_cond = (next_sel != cur) && cur_task && (cur_stat == ST_RUNNING);

  pts_table #(
    .MAX_TASKS (MAX_TASKS),
    .TICK_WIDTH(TICK_WIDTH)
  ) u_table (
    .clk    (clk),
    .we     (we),
    .wr_addr(wr_addr),
    .wr_prio(wr_prio),
    .wr_stat(wr_stat),
    .wr_wait(wr_wait),
    .rd_addr(rd_idx[ADDR_W-1:0]),
    .rd_prio(rd_prio),
    .rd_stat(rd_stat),
    .rd_wait(rd_wait)
  );

  pts_picker #(
    .MAX_TASKS(MAX_TASKS)
  ) u_picker (
    .clk     (clk),
    .clear   (state == S_OP),
    .valid   ((state == S_SCAN) && rv),
    .idx     (rv_idx),
    .prio    (rd_prio),
    .stat    (upd_stat),
    .best_idx(next_sel)
  );

  // tick countdown of the entry just read
  always_comb begin
    upd_we   = 1'b0;
    upd_stat = rd_stat;
    upd_wait = rd_wait;
    if ((op_q == OP_TICK) && (rd_stat == ST_WAITING)) begin
      upd_we = 1'b1;
      if (rd_wait <= TICK_WIDTH'(1)) begin
        upd_wait = '0;
        upd_stat = ST_READY;
      end else begin
        upd_wait = rd_wait - TICK_WIDTH'(1);
      end
    end
  end

  always_comb begin
    we      = '0;
    wr_addr = '0;
    wr_prio = prio_q;
    wr_stat = ST_READY;
    wr_wait = '0;
    unique case (state)
      S_OP: begin
        unique case (op_q)
          OP_CREATE: begin
            if (count < IDX_W'(MAX_TASKS)) begin
              we      = '{prio: 1'b1, stat: 1'b1, cnt: 1'b1};
              wr_addr = count[ADDR_W-1:0];
              wr_stat = auto_q ? ST_READY : ST_SUSPENDED;
            end
          end
          OP_DELAY: begin
            if (cur_task) begin
              we.stat = 1'b1;
              we.cnt  = 1'b1;
              wr_addr = cur[ADDR_W-1:0];
              wr_stat = ST_WAITING;
              wr_wait = (dly == '0) ? TICK_WIDTH'(1) : dly;
            end
          end
          OP_SUSPEND: begin
            if (cur_task) begin
              we.stat = 1'b1;
              wr_addr = cur[ADDR_W-1:0];
              wr_stat = ST_SUSPENDED;
            end
          end
          OP_ACTIVATE: begin
            if (TGT_W'(target_q) < TGT_W'(count)) begin
              we.stat = 1'b1;
              wr_addr = ADDR_W'(target_q);
              wr_stat = ST_READY;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (rv && upd_we) begin
          we.stat = 1'b1;
          we.cnt  = 1'b1;
          wr_addr = rv_idx[ADDR_W-1:0];
          wr_stat = upd_stat;
          wr_wait = upd_wait;
        end
      end
      S_FIX: begin
        if (fix_cond) begin
          we.stat = 1'b1;
          wr_addr = cur[ADDR_W-1:0];
          wr_stat = ST_READY;
        end
      end
      S_SET: begin
        if (next_sel < IDX_W'(MAX_TASKS)) begin
          we.stat = 1'b1;
          wr_addr = next_sel[ADDR_W-1:0];
          wr_stat = ST_RUNNING;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      cur    <= IDX_W'(MAX_TASKS);
      gclock <= '0;
      done   <= 1'b0;
      rv     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_OP;
          end
        end
        S_OP: begin
          if ((op_q == OP_CREATE) && (count < IDX_W'(MAX_TASKS))) begin
            count <= count + IDX_W'(1);
          end
          if (op_q == OP_TICK) begin
            gclock <= gclock + TICK_WIDTH'(1);
          end
          rv    <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          rv <= issue;
          if (!issue && !rv) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state <= S_SET;
        end
        S_SET: begin
          cur   <= next_sel;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && start) begin
      op_q     <= operation;
      prio_q   <= prio;
      auto_q   <= auto_start;
      ticks_q  <= delay_ticks;
      target_q <= target_task;
    end
    if (state == S_OP) begin
      rd_idx   <= '0;
      cur_stat <= ST_SUSPENDED;
      handle   <= '0;
      refused  <= 1'b0;
      if (op_q == OP_CREATE) begin
        if (count < IDX_W'(MAX_TASKS)) begin
          handle <= count;
        end else begin
          refused <= 1'b1;
        end
      end
    end
    if (state == S_SCAN) begin
      if (issue) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end
      rv_idx <= rd_idx;
      if (rv && (rv_idx == cur)) begin
        cur_stat <= upd_stat;
      end
    end
    if (state == S_SET) begin
      running_task <= 4'(next_sel);
      switch_flag  <= (next_sel != cur);
      new_handle   <= 3'(handle);
      status       <= refused;
      clock_value  <= 32'(gclock);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pts_table.sv
// ----------------------------------------------------------------------------
// pts_table
// Task table memory: priority, status and wait count per task, one write
// port with field enables, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_table import pts_pkg::*; #(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF,
  localparam int ADDR_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  wire logic                  clk,
  input  wire pts_we_t               we,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  wire logic [7:0]            wr_prio,
  input  wire tstat_t                wr_stat,
  input  wire logic [TICK_WIDTH-1:0] wr_wait,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  output logic [7:0]                 rd_prio,
  output tstat_t                     rd_stat,
  output logic [TICK_WIDTH-1:0]      rd_wait
);

  logic [7:0]            prio_mem [MAX_TASKS];
  tstat_t                stat_mem [MAX_TASKS];
  logic [TICK_WIDTH-1:0] wait_mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (we.prio) begin
      prio_mem[wr_addr] <= wr_prio;
    end
    if (we.stat) begin
      stat_mem[wr_addr] <= wr_stat;
    end
    if (we.cnt) begin
      wait_mem[wr_addr] <= wr_wait;
    end
    rd_prio <= prio_mem[rd_addr];
    rd_stat <= stat_mem[rd_addr];
    rd_wait <= wait_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pts_picker.sv
// ----------------------------------------------------------------------------
// pts_picker
// Shared compare unit: keeps the best ready or running task seen so far,
// one entry per cycle; strict compare so the lowest index wins on a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_picker import pts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  localparam int IDX_W    = $clog2(MAX_TASKS + 1)
) (
  input  wire logic             clk,
  input  wire logic             clear,
  input  wire logic             valid,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [7:0]       prio,
  input  wire tstat_t           stat,
  output logic [IDX_W-1:0]      best_idx
);

  logic [7:0] best_prio;
  logic       qual;

  assign qual = (stat == ST_READY) || (stat == ST_RUNNING);

  always_ff @(posedge clk) begin
    if (clear) begin
      best_prio <= '0;
      best_idx  <= IDX_W'(MAX_TASKS);
    end else if (valid && qual && (prio > best_prio)) begin
      best_prio <= prio;
      best_idx  <= idx;
    end
  end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the priority task scheduler against its own prediction of the task
// table and dispatcher. A directed part covers idle no-ops, unknown codes,
// out-of-range activation, equal priorities, zero delays and a full table;
// random operation mixes follow under varied sender pacing. Each done strobe
// is compared field by field with the oldest predicted dispatch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pts_pkg::*;

  localparam int NTASK       = MAX_TASKS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 509;

  localparam logic [2:0] OP_UNUSED5 = 3'd5;
  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  prio;
    logic        auto_start;
    logic [31:0] ticks;
    logic [2:0]  target;
  } sched_item_t;

  typedef struct packed {
    logic [3:0]  running;
    logic        sw;
    logic [2:0]  handle;
    logic        refused;
    logic [31:0] clock;
  } dispatch_t;

  class sched_scoreboard;
    logic [7:0]  prio_tab [NTASK];
    tstat_t      stat_tab [NTASK];
    logic [31:0] wait_tab [NTASK];
    int          n_tasks;
    int          cur_idx;
    logic [31:0] sys_clock;
    dispatch_t   expected_dispatch [$];
    int          errors;
    int          checked;
    int          switches;
    int          refusals;

    function new();
      n_tasks   = 0;
      cur_idx   = NTASK;
      sys_clock = '0;
      errors    = 0;
      checked   = 0;
      switches  = 0;
      refusals  = 0;
    endfunction

    function int pending();
      return expected_dispatch.size();
    endfunction

    function void apply_item(sched_item_t it);
      dispatch_t r;
      int        best;
      int        best_prio;
      int        prev;
      r = '0;
      case (it.op)
        OP_CREATE: begin
          if (n_tasks < NTASK) begin
            r.handle          = 3'(n_tasks);
            prio_tab[n_tasks] = it.prio;
            stat_tab[n_tasks] = it.auto_start ? ST_READY : ST_SUSPENDED;
            wait_tab[n_tasks] = '0;
            n_tasks++;
          end else begin
            r.refused = 1'b1;
            refusals++;
          end
        end
        OP_DELAY: begin
          if (cur_idx < n_tasks) begin
            stat_tab[cur_idx] = ST_WAITING;
            wait_tab[cur_idx] = (it.ticks == '0) ? 32'd1 : it.ticks;
          end
        end
        OP_SUSPEND: begin
          if (cur_idx < n_tasks) stat_tab[cur_idx] = ST_SUSPENDED;
        end
        OP_ACTIVATE: begin
          if (int'(it.target) < n_tasks) stat_tab[it.target] = ST_READY;
        end
        OP_TICK: begin
          sys_clock++;
          for (int i = 0; i < n_tasks; i++) begin
            if (stat_tab[i] == ST_WAITING) begin
              if (wait_tab[i] <= 32'd1) begin
                wait_tab[i] = '0;
                stat_tab[i] = ST_READY;
              end else begin
                wait_tab[i]--;
              end
            end
          end
        end
        default: ;
      endcase

      best      = NTASK;
      best_prio = 0;
      for (int i = 0; i < n_tasks; i++) begin
        if ((stat_tab[i] == ST_READY || stat_tab[i] == ST_RUNNING) &&
            int'(prio_tab[i]) > best_prio) begin
          best_prio = prio_tab[i];
          best      = i;
        end
      end
      prev = cur_idx;
      if (best != prev && prev < n_tasks && stat_tab[prev] == ST_RUNNING)
        stat_tab[prev] = ST_READY;
      if (best < NTASK) stat_tab[best] = ST_RUNNING;
      cur_idx = best;
      if (best != prev) switches++;

      r.running = 4'(best);
      r.sw      = (best != prev);
      r.clock   = sys_clock;
      expected_dispatch.push_back(r);
    endfunction

    function void compare_dispatch(dispatch_t got);
      dispatch_t exp_r;
      if (expected_dispatch.size() == 0) begin
        $error("dispatch result with no item pending");
        errors++;
        return;
      end
      exp_r = expected_dispatch.pop_front();
      checked++;
      if (got.running !== exp_r.running) begin
        $error("running_task: expected %0d, got %0d", exp_r.running, got.running);
        errors++;
      end
      if (got.sw !== exp_r.sw) begin
        $error("switch_flag: expected %0d, got %0d", exp_r.sw, got.sw);
        errors++;
      end
      if (got.handle !== exp_r.handle) begin
        $error("new_handle: expected %0d, got %0d", exp_r.handle, got.handle);
        errors++;
      end
      if (got.refused !== exp_r.refused) begin
        $error("status: expected %0d, got %0d", exp_r.refused, got.refused);
        errors++;
      end
      if (got.clock !== exp_r.clock) begin
        $error("clock_value: expected %0d, got %0d", exp_r.clock, got.clock);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  operation;
  logic [7:0]  prio;
  logic        auto_start;
  logic [31:0] delay_ticks;
  logic [2:0]  target_task;
  logic        done;
  logic [3:0]  running_task;
  logic        switch_flag;
  logic [2:0]  new_handle;
  logic        status;
  logic [31:0] clock_value;

  int              send_gap_pct = 0;
  int              cycle_count  = 0;
  sched_scoreboard sb           = new();

  priority_task_scheduler dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.compare_dispatch(dispatch_t'{running_task, switch_flag, new_handle, status,
                                        clock_value});
      if (start && !busy)
        sb.apply_item(sched_item_t'{operation, prio, auto_start, delay_ticks,
                                    target_task});
    end
  end

  function automatic sched_item_t mk(logic [2:0] op, logic [7:0] p, logic a,
                                     logic [31:0] t, logic [2:0] tgt);
    return sched_item_t'{op, p, a, t, tgt};
  endfunction

  function automatic sched_item_t random_item();
    sched_item_t it;
    int          sel;
    sel           = $urandom_range(99);
    it.prio       = 8'($urandom);
    it.auto_start = 1'($urandom);
    it.target     = 3'($urandom);
    case ($urandom_range(9))
      0:       it.ticks = '0;
      1:       it.ticks = $urandom;
      default: it.ticks = $urandom_range(1, 6);
    endcase
    if (sel < 4)       it.op = OP_CREATE;
    else if (sel < 22) it.op = OP_DELAY;
    else if (sel < 32) it.op = OP_SUSPEND;
    else if (sel < 55) it.op = OP_ACTIVATE;
    else if (sel < 97) it.op = OP_TICK;
    else               it.op = 3'($urandom_range(OP_UNUSED5, OP_UNUSED7));
    return it;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(sched_item_t it);
    operation   <= it.op;
    prio        <= it.prio;
    auto_start  <= it.auto_start;
    delay_ticks <= it.ticks;
    target_task <= it.target;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic run_directed();
    send_item(mk(OP_TICK,     8'd0,   1'b0, 32'd0,          3'd0));
    send_item(mk(OP_DELAY,    8'd0,   1'b0, 32'd5,          3'd0));
    send_item(mk(OP_SUSPEND,  8'd0,   1'b0, 32'd0,          3'd0));
    send_item(mk(OP_ACTIVATE, 8'd0,   1'b0, 32'd0,          3'd7));
    send_item(mk(OP_UNUSED5,  8'hFF,  1'b1, 32'hFFFFFFFF,   3'd7));
    // priority zero never beats idle
    send_item(mk(OP_CREATE,   8'd0,   1'b1, 32'd0,          3'd0));
    send_item(mk(OP_CREATE,   8'd255, 1'b0, 32'd0,          3'd0));
    send_item(mk(OP_ACTIVATE, 8'd0,   1'b0, 32'd0,          3'd1));
    send_item(mk(OP_ACTIVATE, 8'd0,   1'b0, 32'd0,          3'd5));
    send_item(mk(OP_CREATE,   8'd255, 1'b1, 32'd0,          3'd0));
    send_item(mk(OP_DELAY,    8'd0,   1'b0, 32'd0,          3'd0));
    send_item(mk(OP_TICK,     8'd0,   1'b0, 32'd0,          3'd0));
    send_item(mk(OP_DELAY,    8'd0,   1'b0, 32'd3,          3'd0));
    send_item(mk(OP_SUSPEND,  8'd0,   1'b0, 32'd0,          3'd0));
    send_item(mk(OP_UNUSED6,  8'd0,   1'b0, 32'd0,          3'd0));
    send_item(mk(OP_UNUSED7,  8'd0,   1'b0, 32'd0,          3'd0));
    send_item(mk(OP_CREATE,   8'd100, 1'b1, 32'd0,          3'd0));
    send_item(mk(OP_CREATE,   8'd1,   1'b1, 32'd0,          3'd0));
    send_item(mk(OP_CREATE,   8'd200, 1'b0, 32'd0,          3'd0));
    send_item(mk(OP_CREATE,   8'd128, 1'b1, 32'd0,          3'd0));
    send_item(mk(OP_CREATE,   8'd50,  1'b1, 32'd0,          3'd0));
    // table full
    send_item(mk(OP_CREATE,   8'd255, 1'b1, 32'd0,          3'd0));
    send_item(mk(OP_DELAY,    8'd0,   1'b0, 32'hFFFFFFFF,   3'd0));
    send_item(mk(OP_ACTIVATE, 8'd0,   1'b0, 32'd0,          3'd7));
    send_item(mk(OP_TICK,     8'd0,   1'b0, 32'd0,          3'd0));
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    operation   = OP_TICK;
    prio        = '0;
    auto_start  = 1'b0;
    delay_ticks = '0;
    target_task = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct = 19;
    run_directed();
    for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    send_gap_pct = 65;
    for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    send_gap_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d dispatch results over three pacing phases.", sb.checked);
    $display("Saw %0d task switches and %0d refused creates; final clock %0d.",
             sb.switches, sb.refusals, sb.sys_clock);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
